// ----- src/dacp_pkg.sv -----
`default_nettype none

package dacp_pkg;

    // item actions
    localparam logic [1:0] ACT_RUN_D = 2'd0;
    localparam logic [1:0] ACT_RUN_Q = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [2:0] CFG_INTEG_GAIN     = 3'd1;
    localparam logic [2:0] CFG_DERIV_GAIN     = 3'd2;
    localparam logic [2:0] CFG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [2:0] CFG_OUTPUT_LIMIT   = 3'd4;

    localparam logic [30:0] LimitReset   = 31'd412877;
    localparam logic [23:0] TimerMax     = 24'hFFFFFF;
    localparam logic [23:0] MaxTicks     = 24'd90000;
    localparam logic [16:0] DefaultTicks = 17'd9000;
    localparam logic [16:0] MinDTicks    = 17'd9;
    localparam logic [23:0] TicksPerSec  = 24'd9000000;
    localparam logic [50:0] DBound       = 51'd1 << 50;

    // 72-bit dividend, two quotient bits per cycle
    localparam logic [5:0] DivLast = 6'd35;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'b0000_0000_0000_0001,
        ST_PREP   = 16'b0000_0000_0000_0010,
        ST_MUL_P  = 16'b0000_0000_0000_0100,
        ST_MUL_I  = 16'b0000_0000_0000_1000,
        ST_MUL_T0 = 16'b0000_0000_0001_0000,
        ST_MUL_T1 = 16'b0000_0000_0010_0000,
        ST_ACC_T  = 16'b0000_0000_0100_0000,
        ST_DIV_I  = 16'b0000_0000_1000_0000,
        ST_INTEG  = 16'b0000_0001_0000_0000,
        ST_MUL_D  = 16'b0000_0010_0000_0000,
        ST_MUL_A0 = 16'b0000_0100_0000_0000,
        ST_MUL_A1 = 16'b0000_1000_0000_0000,
        ST_ACC_A  = 16'b0001_0000_0000_0000,
        ST_DIV_D  = 16'b0010_0000_0000_0000,
        ST_DSAT   = 16'b0100_0000_0000_0000,
        ST_SUM    = 16'b1000_0000_0000_0000
    } state_t;

endpackage

`default_nettype wire

// ----- src/dual_axis_current_pid_top.sv -----
// a run item takes one division, or two when the derivative term
// is used (elapsed ticks above nine); the shared 33x32 multiplier
// and the radix-4 divider serve one item at a time, and no new item
// is taken until the result of the last one is registered
// clear items and unused actions give no result
// reset: synchronous active-low aresetn; gains to zero, limits to 412877, axis state cleared
`default_nettype none

module dual_axis_current_pid_top
    import dacp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [31:0] s_error_value,
    input  wire logic [23:0] s_timer_value,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_drive_value
);

    state_t state_reg, state_next;

    logic [31:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [30:0] integral_limit_reg, output_limit_reg;

    logic signed [31:0] integral_sum_reg [2];
    logic [31:0]        previous_error_reg [2];
    logic [23:0]        previous_timer_reg [2];

    logic [5:0]  cnt_reg;
    logic        m_valid_reg;
    logic [31:0] m_drive_value_reg;

    // datapath registers
    logic               ax_reg;
    logic [31:0]        e_reg;
    logic [23:0]        now_reg;
    logic [16:0]        ticks_reg;
    logic [32:0]        de_mag_reg;
    logic               sd_reg;
    logic [64:0]        prod_reg;
    logic [47:0]        opnd_reg;
    logic [71:0]        acc_reg;
    logic [23:0]        rem_reg;
    logic signed [47:0] p_reg;
    logic signed [31:0] integ_reg;
    logic signed [51:0] d_reg;

    logic in_fire, out_free;
    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign in_fire       = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_drive_value = m_drive_value_reg;
    assign out_free      = !m_valid_reg || m_ready;

    // operand magnitudes, signs handled apart
    logic [31:0] e_mag, kp_mag, ki_mag, kd_mag;
    logic        sp, si;
    assign e_mag  = e_reg[31] ? (~e_reg + 32'd1) : e_reg;
    assign kp_mag = prop_gain_reg[31] ? (~prop_gain_reg + 32'd1) : prop_gain_reg;
    assign ki_mag = integ_gain_reg[31] ? (~integ_gain_reg + 32'd1) : integ_gain_reg;
    assign kd_mag = deriv_gain_reg[31] ? (~deriv_gain_reg + 32'd1) : deriv_gain_reg;
    assign sp     = prop_gain_reg[31] ^ e_reg[31];
    assign si     = integ_gain_reg[31] ^ e_reg[31];

    // elapsed ticks and error difference for the chosen axis
    logic [23:0] last_timer, raw_ticks;
    logic [16:0] ticks_calc;
    logic [31:0] prev_err;
    logic [32:0] de, de_mag;
    assign last_timer = previous_timer_reg[ax_reg];
    assign prev_err   = previous_error_reg[ax_reg];
    assign raw_ticks  = (now_reg < last_timer) ? (last_timer - now_reg)
                                               : (TimerMax - now_reg + last_timer);
    always_comb begin
        if (last_timer == 24'd0 || raw_ticks == 24'd0 || raw_ticks > MaxTicks) begin
            ticks_calc = DefaultTicks;
        end else begin
            ticks_calc = raw_ticks[16:0];
        end
    end
    assign de     = {e_reg[31], e_reg} - {prev_err[31], prev_err};
    assign de_mag = de[32] ? (~de + 33'd1) : de;

    // shared multiplier
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_prod;
    always_comb begin
        unique case (state_reg)
            ST_MUL_P: begin
                mul_a = {1'b0, e_mag};
                mul_b = kp_mag;
            end
            ST_MUL_I: begin
                mul_a = {1'b0, e_mag};
                mul_b = ki_mag;
            end
            ST_MUL_T0: begin
                mul_a = {9'd0, prod_reg[39:16]};
                mul_b = {15'd0, ticks_reg};
            end
            ST_MUL_T1: begin
                mul_a = {9'd0, opnd_reg[47:24]};
                mul_b = {15'd0, ticks_reg};
            end
            ST_MUL_D: begin
                mul_a = de_mag_reg;
                mul_b = kd_mag;
            end
            ST_MUL_A0: begin
                mul_a = {9'd0, prod_reg[39:16]};
                mul_b = {8'd0, TicksPerSec};
            end
            ST_MUL_A1: begin
                mul_a = {9'd0, opnd_reg[47:24]};
                mul_b = {8'd0, TicksPerSec};
            end
            default: begin
                mul_a = 33'd0;
                mul_b = 32'd0;
            end
        endcase
    end
    assign mul_prod = {32'd0, mul_a} * {33'd0, mul_b};

    // shared divider, two restoring steps per cycle
    logic [23:0] divisor, r1, r2;
    logic [24:0] t1, t2;
    logic        ge1, ge2;
    logic [71:0] a1, a2;
    assign divisor = (state_reg == ST_DIV_I) ? TicksPerSec : {7'd0, ticks_reg};
    assign t1  = {rem_reg, acc_reg[71]};
    assign ge1 = t1 >= {1'b0, divisor};
    assign r1  = ge1 ? 24'(t1 - {1'b0, divisor}) : t1[23:0];
    assign a1  = {acc_reg[70:0], ge1};
    assign t2  = {r1, a1[71]};
    assign ge2 = t2 >= {1'b0, divisor};
    assign r2  = ge2 ? 24'(t2 - {1'b0, divisor}) : t2[23:0];
    assign a2  = {a1[70:0], ge2};

    // proportional term
    logic [46:0]        p_mag;
    logic signed [47:0] p_calc;
    assign p_mag  = prod_reg[62:16];
    assign p_calc = sp ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});

    // integral update with clamp
    logic signed [47:0] inc, isum, ilim, integ_calc;
    assign inc  = si ? -$signed({6'd0, acc_reg[41:0]}) : $signed({6'd0, acc_reg[41:0]});
    assign isum = 48'(integral_sum_reg[ax_reg]) + inc;
    assign ilim = $signed({17'd0, integral_limit_reg});
    always_comb begin
        if (isum > ilim) begin
            integ_calc = ilim;
        end else if (isum < -ilim) begin
            integ_calc = -ilim;
        end else begin
            integ_calc = isum;
        end
    end

    // derivative magnitude bound
    logic [50:0]        d_mag;
    logic signed [51:0] d_calc;
    assign d_mag  = (|acc_reg[71:50]) ? DBound : acc_reg[50:0];
    assign d_calc = sd_reg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});

    // output sum and clamp
    logic signed [53:0] total, olim, out_calc;
    assign total = 54'(p_reg) + 54'(integ_reg) + 54'(d_reg);
    assign olim  = $signed({23'd0, output_limit_reg});
    always_comb begin
        if (total > olim) begin
            out_calc = olim;
        end else if (total < -olim) begin
            out_calc = -olim;
        end else begin
            out_calc = total;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_action == ACT_RUN_D || s_action == ACT_RUN_Q)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:   state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_MUL_T0;
            ST_MUL_T0: state_next = ST_MUL_T1;
            ST_MUL_T1: state_next = ST_ACC_T;
            ST_ACC_T:  state_next = ST_DIV_I;
            ST_DIV_I: begin
                if (cnt_reg == 6'd0) begin
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG: begin
                state_next = (ticks_reg > MinDTicks) ? ST_MUL_D : ST_SUM;
            end
            ST_MUL_D:  state_next = ST_MUL_A0;
            ST_MUL_A0: state_next = ST_MUL_A1;
            ST_MUL_A1: state_next = ST_ACC_A;
            ST_ACC_A:  state_next = ST_DIV_D;
            ST_DIV_D: begin
                if (cnt_reg == 6'd0) begin
                    state_next = ST_DSAT;
                end
            end
            ST_DSAT:   state_next = ST_SUM;
            ST_SUM: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control, configuration and axis state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= 6'd0;
            m_valid_reg        <= 1'b0;
            prop_gain_reg      <= 32'd0;
            integ_gain_reg     <= 32'd0;
            deriv_gain_reg     <= 32'd0;
            integral_limit_reg <= LimitReset;
            output_limit_reg   <= LimitReset;
            for (int i = 0; i < 2; i++) begin
                integral_sum_reg[i]   <= 32'sd0;
                previous_error_reg[i] <= 32'd0;
                previous_timer_reg[i] <= 24'd0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PROP_GAIN:      prop_gain_reg      <= cfg_data;
                    CFG_INTEG_GAIN:     integ_gain_reg     <= cfg_data;
                    CFG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data;
                    CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[30:0];
                    CFG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (in_fire && s_action == ACT_CLEAR) begin
                for (int i = 0; i < 2; i++) begin
                    integral_sum_reg[i]   <= 32'sd0;
                    previous_error_reg[i] <= 32'd0;
                    previous_timer_reg[i] <= 24'd0;
                end
            end

            if (state_reg == ST_ACC_T || state_reg == ST_ACC_A) begin
                cnt_reg <= DivLast;
            end else if ((state_reg == ST_DIV_I || state_reg == ST_DIV_D) && cnt_reg != 6'd0) begin
                cnt_reg <= cnt_reg - 6'd1;
            end

            if (state_reg == ST_SUM && out_free) begin
                m_valid_reg                <= 1'b1;
                integral_sum_reg[ax_reg]   <= integ_reg;
                previous_error_reg[ax_reg] <= e_reg;
                previous_timer_reg[ax_reg] <= now_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ax_reg  <= s_action[0];
            e_reg   <= s_error_value;
            now_reg <= s_timer_value;
        end

        unique case (state_reg)
            ST_PREP: begin
                ticks_reg  <= ticks_calc;
                de_mag_reg <= de_mag;
                sd_reg     <= deriv_gain_reg[31] ^ de[32];
            end
            ST_MUL_P: begin
                prod_reg <= mul_prod;
            end
            ST_MUL_I: begin
                prod_reg <= mul_prod;
                p_reg    <= p_calc;
            end
            ST_MUL_T0, ST_MUL_A0: begin
                // keep the shifted product for its upper half
                opnd_reg <= prod_reg[63:16];
                prod_reg <= mul_prod;
            end
            ST_MUL_T1, ST_MUL_A1: begin
                acc_reg  <= {7'd0, prod_reg};
                prod_reg <= mul_prod;
            end
            ST_ACC_T, ST_ACC_A: begin
                acc_reg <= acc_reg + {prod_reg[47:0], 24'd0};
                rem_reg <= 24'd0;
            end
            ST_DIV_I, ST_DIV_D: begin
                acc_reg <= a2;
                rem_reg <= r2;
            end
            ST_INTEG: begin
                integ_reg <= 32'(integ_calc);
                d_reg     <= 52'sd0;
            end
            ST_MUL_D: begin
                prod_reg <= mul_prod;
            end
            ST_DSAT: begin
                d_reg <= d_calc;
            end
            ST_SUM: begin
                if (out_free) begin
                    m_drive_value_reg <= 32'(out_calc);
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

module testbench;
    import dacp_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam longint Q_ONE          = 65536;
    localparam longint TICK_RATE      = 9000000;
    localparam longint FALLBACK_TICKS = 9000;
    localparam longint MAX_ELAPSED    = 90000;
    localparam longint MIN_D_TICKS    = 9;
    localparam longint TIMER_WRAP     = 64'hFFFFFF;
    localparam longint D_LIMIT        = 64'sd1 << 50;
    localparam longint Q_SAT          = 64'sd1 << 27;

    localparam int SETTLE_CYCLES  = 120;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 6000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = '0;
    logic [31:0] cfg_data      = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action      = '0;
    logic [31:0] s_error_value = '0;
    logic [23:0] s_timer_value = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [31:0] m_drive_value;

    // predictor copy of registers and per-axis loop state
    logic [31:0] gain_p, gain_i, gain_d;
    logic [30:0] clamp_integ, clamp_drive;
    logic [31:0] integ_state [2];
    logic [31:0] err_prev [2];
    logic [23:0] timer_prev [2];

    logic [31:0] drive_expected [$];
    int          fail_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct    = 0;
    bit          hold_request = 1'b0;
    int          idle_cycles  = 0;
    logic [23:0] timer_now    = 24'h800000;

    dual_axis_current_pid_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_error_value (s_error_value),
        .s_timer_value (s_timer_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_value (m_drive_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp_sym(input longint x, input longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    task automatic clear_loop_state();
        for (int i = 0; i < 2; i++) begin
            integ_state[i] = '0;
            err_prev[i]    = '0;
            timer_prev[i]  = '0;
        end
    endtask

    task automatic predict_pid_step(input logic [1:0] act, input logic [31:0] err,
                                    input logic [23:0] tmr);
        int     ax;
        longint ticks, e, p, ai, inc, integ, a, q, r, d, drive;
        if (act == ACT_CLEAR) begin
            clear_loop_state();
            return;
        end
        if (act != ACT_RUN_D && act != ACT_RUN_Q) return;
        ax = (act == ACT_RUN_Q) ? 1 : 0;

        // elapsed ticks of a down counter, with wrap and fallback
        ticks = FALLBACK_TICKS;
        if (timer_prev[ax] != '0) begin
            if (tmr < timer_prev[ax])
                ticks = longint'(timer_prev[ax]) - longint'(tmr);
            else
                ticks = TIMER_WRAP - longint'(tmr) + longint'(timer_prev[ax]);
            if (ticks == 0 || ticks > MAX_ELAPSED) ticks = FALLBACK_TICKS;
        end

        e   = longint'($signed(err));
        p   = (longint'($signed(gain_p)) * e) / Q_ONE;
        ai  = (longint'($signed(gain_i)) * e) / Q_ONE;
        inc = (ai * ticks) / TICK_RATE;
        integ = clamp_sym(longint'($signed(integ_state[ax])) + inc, longint'(clamp_integ));

        d = 0;
        if (ticks > MIN_D_TICKS) begin
            a = (longint'($signed(gain_d)) * (e - longint'($signed(err_prev[ax])))) / Q_ONE;
            q = a / ticks;
            r = a % ticks;
            if (q >= Q_SAT)
                d = D_LIMIT;
            else if (q <= -Q_SAT)
                d = -D_LIMIT;
            else
                d = clamp_sym(q * TICK_RATE + (r * TICK_RATE) / ticks, D_LIMIT);
        end

        drive = clamp_sym(p + integ + d, longint'(clamp_drive));
        integ_state[ax] = integ[31:0];
        err_prev[ax]    = err;
        timer_prev[ax]  = tmr;
        drive_expected.push_back(drive[31:0]);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_PROP_GAIN:      gain_p = data;
            CFG_INTEG_GAIN:     gain_i = data;
            CFG_DERIV_GAIN:     gain_d = data;
            CFG_INTEGRAL_LIMIT: clamp_integ = data[30:0];
            CFG_OUTPUT_LIMIT:   clamp_drive = data[30:0];
            default: ;
        endcase
    endtask

    task automatic program_loop(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [31:0] ilim,
                                input logic [31:0] olim);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_INTEGRAL_LIMIT, ilim);
        write_reg(CFG_OUTPUT_LIMIT, olim);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_item(input logic [1:0] act, input logic [31:0] err,
                              input logic [23:0] tmr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_error_value <= err;
        s_timer_value <= tmr;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_pid_step(act, err, tmr);
    endtask

    // wait for all drive values, then give the block time to finish any work
    task automatic settle_block();
        s_valid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_error();
        logic [31:0] mag;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                mag = $urandom_range(0, 32'h0010_0000);
                return $urandom_range(1) ? -mag : mag;
            end
            6, 7: return $urandom;
            default: begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0001;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_gain(input int unsigned mag_max);
        logic [31:0] mag;
        case ($urandom_range(9))
            7: return $urandom;
            8: return 32'h0;
            9: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: begin
                mag = $urandom_range(0, mag_max);
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(9))
            7: return $urandom;
            8: return 32'h0;
            9: return 32'h7FFF_FFFF;
            default: return $urandom_range(32'h8000, 32'h0040_0000);
        endcase
    endfunction

    // down counter moves on by a random step, now and then out of range
    function automatic logic [23:0] next_timer();
        logic [23:0] step;
        case ($urandom_range(19))
            0: step = '0;
            1: step = 24'($urandom_range(1, 9));
            2: step = 24'($urandom_range(90001, 24'hFFFFFF));
            default: step = 24'($urandom_range(10, 40000));
        endcase
        timer_now = timer_now - step;
        return ($urandom_range(29) == 0) ? 24'd0 : timer_now;
    endfunction

    task automatic test_reset_values();
        offer_item(ACT_RUN_D, 32'h0001_0000, 24'h123456);
        offer_item(ACT_RUN_Q, 32'h8000_0000, 24'h654321);
    endtask

    task automatic test_directed();
        settle_block();
        program_loop(32'h0001_0000, 32'h0032_0000, 32'd131, 32'd412877, 32'd412877);
        offer_item(ACT_RUN_D, 32'h0001_0000, 24'h500000);
        offer_item(ACT_RUN_D, 32'h0000_8000, 24'h500000 - 24'd900);
        offer_item(ACT_RUN_D, 32'h0001_8000, 24'h500000 - 24'd905);
        // same snapshot twice: elapsed wraps far beyond range
        offer_item(ACT_RUN_D, 32'h0, 24'h500000 - 24'd905);
        offer_item(ACT_RUN_Q, 32'h7FFF_FFFF, 24'h000064);
        offer_item(ACT_RUN_Q, 32'h8000_0000, 24'hFFFF00);
        offer_item(ACT_RUN_Q, 32'hFFFF_FFFF, 24'hFFFE00);
        // zero snapshot turns the next run into a first run
        offer_item(ACT_RUN_D, 32'h0002_0000, 24'h000000);
        offer_item(ACT_RUN_D, 32'h0001_0000, 24'h400000);
        offer_item(ACT_UNUSED, 32'h1234_5678, 24'h3FFFF0);
        offer_item(ACT_RUN_D, 32'h0003_0000, 24'h400000 - 24'd10);
        offer_item(ACT_RUN_D, 32'hFFFD_0000, 24'h400000 - 24'd19);
        offer_item(ACT_RUN_Q, 32'h0, 24'hFFFE00 - 24'd90000);
        offer_item(ACT_RUN_Q, 32'h0000_4000, 24'hFFFE00 - 24'd180001);
        offer_item(ACT_CLEAR, 32'hFFFF_FFFF, 24'hFFFFFF);
        offer_item(ACT_RUN_D, 32'hFFFF_0000, 24'h200000);
        offer_item(ACT_RUN_Q, 32'h0000_0001, 24'h1FF000);
        offer_item(ACT_UNUSED, 32'hFFFF_FFFF, 24'hFFFFFF);
        offer_item(ACT_RUN_D, 32'h7FFF_FFFF, 24'hFFFFFF);
        offer_item(ACT_RUN_Q, 32'h8000_0000, 24'h1FE000);
    endtask

    task automatic test_gain_extremes();
        settle_block();
        program_loop(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF);
        offer_item(ACT_RUN_D, 32'h8000_0000, 24'h300000);
        // full-scale error swing over ten ticks saturates the derivative
        offer_item(ACT_RUN_D, 32'h7FFF_FFFF, 24'h300000 - 24'd10);
        offer_item(ACT_RUN_Q, 32'h7FFF_FFFF, 24'h2FFFF0);
        offer_item(ACT_RUN_Q, 32'h8000_0000, 24'h2FFFF0 - 24'd12);
        settle_block();
        // bit 31 of a limit write is not stored
        program_loop(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000);
        offer_item(ACT_RUN_D, 32'h7FFF_FFFF, 24'h2FF000);
        offer_item(ACT_RUN_Q, 32'h8000_0000, 24'h2FE000);
        settle_block();
        program_loop(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_item(ACT_RUN_D, 32'h8000_0000, 24'h2FD000);
        offer_item(ACT_RUN_Q, 32'h7FFF_FFFF, 24'h2FC000);
    endtask

    task automatic test_limit_lowered();
        settle_block();
        program_loop(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0010_0000, 32'h7FFF_FFFF);
        offer_item(ACT_CLEAR, 32'h0, 24'h0);
        offer_item(ACT_RUN_D, 32'h0001_0000, 24'h600000);
        offer_item(ACT_RUN_D, 32'h0001_0000, 24'h600000 - 24'd9000);
        offer_item(ACT_RUN_Q, 32'hFFFF_0000, 24'h5F0000);
        offer_item(ACT_RUN_Q, 32'hFFFF_0000, 24'h5F0000 - 24'd9000);
        settle_block();
        // stored integrals now sit beyond the new bound
        write_reg(CFG_INTEGRAL_LIMIT, 32'h0001_0000);
        cfg_valid <= 1'b0;
        offer_item(ACT_RUN_D, 32'h0, 24'h5E0000);
        offer_item(ACT_RUN_Q, 32'h0, 24'h5E0000 - 24'd5000);
    endtask

    task automatic random_pid_item(output bit counted);
        int unsigned pick;
        pick = $urandom_range(99);
        counted = 1'b1;
        if (pick < 5) begin
            offer_item(ACT_CLEAR, $urandom, 24'($urandom));
        end else if (pick < 8) begin
            counted = 1'b0;
            offer_item(ACT_UNUSED, $urandom, 24'($urandom));
        end else if (pick < 12) begin
            offer_item($urandom_range(1) ? ACT_RUN_Q : ACT_RUN_D, $urandom, 24'($urandom));
        end else begin
            offer_item($urandom_range(1) ? ACT_RUN_Q : ACT_RUN_D, rand_error(), next_timer());
        end
    endtask

    task automatic test_random(input int n_items, input int idle_pct, input int hold_pct);
        bit counted;
        int n;
        settle_block();
        program_loop(rand_gain(32'h0014_0000), rand_gain(32'h0064_0000), rand_gain(700),
                     rand_limit(), rand_limit());
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        n = 0;
        while (n < n_items) begin
            random_pid_item(counted);
            if (counted) n++;
        end
    endtask

    task automatic test_backpressure();
        settle_block();
        program_loop(32'h0002_0000, 32'h0010_0000, 32'd300, 32'h0020_0000, 32'h0030_0000);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b1;
        for (int i = 0; i < 30; i++)
            offer_item($urandom_range(1) ? ACT_RUN_Q : ACT_RUN_D, rand_error(), next_timer());
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
                hold_request = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (drive_expected.size() == 0) begin
                $display("%0t: unexpected drive_value transfer, got %0d",
                         $time, $signed(m_drive_value));
                fail_count++;
            end else begin
                want = drive_expected.pop_front();
                if (m_drive_value !== want) begin
                    $display("%0t: drive_value mismatch, expected %0d, got %0d",
                             $time, $signed(want), $signed(m_drive_value));
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        gain_p      = '0;
        gain_i      = '0;
        gain_d      = '0;
        clamp_integ = 31'd412877;
        clamp_drive = 31'd412877;
        clear_loop_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_directed();
        test_gain_extremes();
        test_limit_lowered();
        test_random(120, 0, 0);
        test_random(120, 51, 0);
        test_random(120, 0, 51);
        test_random(120, 26, 26);
        test_backpressure();
        settle_block();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
